[sv/assert_macros.svh]
// Shared assertion macros for the boundary update core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, ignored while reset is applied.
`define MBCU_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds across reset.
`define MBCU_CHK_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/mbcu_pkg.sv]
package mbcu_pkg;

  localparam int COURANT_W = 18;
  localparam int PERM_W    = 24;
  localparam int FIELD_W   = 32;
  localparam int DIFF_W    = 33;
  localparam int QUOT_W    = 33;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_COURANT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COURANT_Y = 2'd1;

  localparam logic [COURANT_W-1:0] COURANT_RESET = 18'd46341;

  localparam logic signed [FIELD_W+2:0] FIELD_MAX = 35'sd2147483647;
  localparam logic signed [FIELD_W+2:0] FIELD_MIN = -35'sd2147483648;

endpackage

[sv/mur_boundary_cell_update_core.sv]
// Throughput: one request per cycle; busy is always low and the pipeline never stalls.
// The depth is set by the square-root pipeline (one root bit per stage) and the
// 33-stage quotient pipeline. The receiver cannot stall: results are strobed once.
// Reset (rst_n, synchronous, active low) clears all valid bits and loads both
// Courant registers with 46341.
`include "assert_macros.svh"

module mur_boundary_cell_update_core
  import mbcu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_across_x,
  input  logic [PERM_W-1:0]           in_rel_permittivity,
  input  logic signed [FIELD_W-1:0]   in_inner_now,
  input  logic signed [FIELD_W-1:0]   in_inner_before,
  input  logic signed [FIELD_W-1:0]   in_edge_before,
  output logic                        out_valid,
  output logic signed [FIELD_W-1:0]   out_edge_new,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COURANT_W-1:0]        cfg_wdata
);

  // Radicand is the permittivity scaled up by the fraction width so that the
  // root comes out with the same number of fraction bits.
  localparam int RAD_W = PERM_W + FRAC_BITS;
  localparam int RW    = (RAD_W + 1) / 2;
  localparam int SQ_W  = 2 * RW;
  localparam int DW    = ((RW > COURANT_W) ? RW : COURANT_W) + 1;
  localparam int PW    = DIFF_W + DW - 1;
  localparam int NW    = PW + 1;
  localparam int SB1_W = COURANT_W + DIFF_W + FIELD_W;
  localparam int SB2_W = 2 + FIELD_W;
  localparam int LAT   = RW + QUOT_W + 5;

  // Configuration registers. Writes to unknown indexes are dropped.
  logic [COURANT_W-1:0] courant_x_r;
  logic [COURANT_W-1:0] courant_y_r;
  logic                 cfg_unmapped;

  assign cfg_unmapped = cfg_we && cfg_index != REG_COURANT_X && cfg_index != REG_COURANT_Y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      courant_x_r <= COURANT_RESET;
      courant_y_r <= COURANT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COURANT_X: courant_x_r <= cfg_wdata;
        REG_COURANT_Y: courant_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline has no backpressure, so a request is taken every cycle.
  assign busy = 1'b0;

  // Stage 1: pick the Courant ratio for the edge axis and form the exact
  // 33-bit difference inner_now - edge_before.
  logic                      in_v_r;
  logic [COURANT_W-1:0]      s_r;
  logic signed [DIFF_W-1:0]  d_r;
  logic signed [FIELD_W-1:0] ib_r;
  logic [PERM_W-1:0]         eps_r;
  logic signed [DIFF_W-1:0]  d_nxt;

  assign d_nxt = $signed({in_inner_now[FIELD_W-1], in_inner_now})
               - $signed({in_edge_before[FIELD_W-1], in_edge_before});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s_r   <= in_across_x ? courant_x_r : courant_y_r;
    d_r   <= d_nxt;
    ib_r  <= in_inner_before;
    eps_r <= in_rel_permittivity;
  end

  // Square root of the permittivity, carrying the other operands alongside.
  logic              sq_v;
  logic [RW-1:0]     sq_root;
  logic [SB1_W-1:0]  sq_sb;

  mbcu_sqrt_pipe #(
    .RW  (RW),
    .SBW (SB1_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (in_v_r),
    .in_rad   (SQ_W'({eps_r, {FRAC_BITS{1'b0}}})),
    .in_sb    ({s_r, d_r, ib_r}),
    .out_v    (sq_v),
    .out_root (sq_root),
    .out_sb   (sq_sb)
  );

  logic [COURANT_W-1:0]      sq_s;
  logic signed [DIFF_W-1:0]  sq_d;
  logic signed [FIELD_W-1:0] sq_ib;

  assign sq_s  = sq_sb[SB1_W-1 -: COURANT_W];
  assign sq_d  = $signed(sq_sb[FIELD_W +: DIFF_W]);
  assign sq_ib = $signed(sq_sb[FIELD_W-1:0]);

  // Coefficient stage: denominator s + r, numerator magnitude |s - r|, and
  // the sign of the final correction as the XOR of both operand signs.
  logic                      c_v_r;
  logic [DW-1:0]             den_r;
  logic [DW-2:0]             nmag_r;
  logic [DIFF_W-1:0]         dmag_r;
  logic                      neg_r;
  logic signed [FIELD_W-1:0] c_ib_r;
  logic [DW-1:0]             s_ext;
  logic [DW-1:0]             r_ext;
  logic                      nneg;

  assign s_ext = DW'(sq_s);
  assign r_ext = DW'(sq_root);
  assign nneg  = r_ext > s_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    den_r  <= s_ext + r_ext;
    nmag_r <= nneg ? (DW-1)'(r_ext - s_ext) : (DW-1)'(s_ext - r_ext);
    dmag_r <= sq_d[DIFF_W-1] ? DIFF_W'(-sq_d) : DIFF_W'(sq_d);
    neg_r  <= sq_d[DIFF_W-1] ^ nneg;
    c_ib_r <= sq_ib;
  end

  // Product stage: |d| * |s - r|.
  logic                      p_v_r;
  logic [PW-1:0]             prod_r;
  logic [DW-1:0]             p_den_r;
  logic                      p_neg_r;
  logic signed [FIELD_W-1:0] p_ib_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= PW'(dmag_r) * PW'(nmag_r);
    p_den_r <= den_r;
    p_neg_r <= neg_r;
    p_ib_r  <= c_ib_r;
  end

  // Rounding stage: add half the denominator so the truncating divider
  // rounds to nearest, ties away from zero on the magnitude.
  logic                      n_v_r;
  logic [NW-1:0]             num_r;
  logic [DW-1:0]             n_den_r;
  logic                      n_neg_r;
  logic                      n_dzero_r;
  logic signed [FIELD_W-1:0] n_ib_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_v_r <= 1'b0;
    end else begin
      n_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    num_r     <= NW'(prod_r) + NW'(p_den_r >> 1);
    n_den_r   <= p_den_r;
    n_neg_r   <= p_neg_r;
    n_dzero_r <= (p_den_r == '0);
    n_ib_r    <= p_ib_r;
  end

  // Quotient fits in 33 bits because |s - r| never exceeds s + r.
  logic              dv_v;
  logic [QUOT_W-1:0] dv_quot;
  logic [SB2_W-1:0]  dv_sb;

  mbcu_div_pipe #(
    .DW  (DW),
    .NW  (NW),
    .QW  (QUOT_W),
    .SBW (SB2_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (n_v_r),
    .in_num   (num_r),
    .in_den   (n_den_r),
    .in_sb    ({n_neg_r, n_dzero_r, n_ib_r}),
    .out_v    (dv_v),
    .out_quot (dv_quot),
    .out_sb   (dv_sb)
  );

  // Output stage: apply the sign, add inner_before and saturate. A zero
  // denominator means a zero coefficient, so the divider result is dropped.
  logic                      out_valid_r;
  logic signed [FIELD_W-1:0] out_edge_new_r;
  logic signed [FIELD_W-1:0] out_edge_new_nxt;
  logic signed [QUOT_W:0]    q_sgn;
  logic signed [FIELD_W+2:0] sum;
  logic                      dv_neg;
  logic                      dv_dzero;
  logic signed [FIELD_W-1:0] dv_ib;

  assign dv_neg   = dv_sb[SB2_W-1];
  assign dv_dzero = dv_sb[SB2_W-2];
  assign dv_ib    = $signed(dv_sb[FIELD_W-1:0]);

  always_comb begin
    if (dv_dzero) begin
      q_sgn = '0;
    end else if (dv_neg) begin
      q_sgn = -$signed({1'b0, dv_quot});
    end else begin
      q_sgn = $signed({1'b0, dv_quot});
    end
    sum = (FIELD_W+3)'(dv_ib) + (FIELD_W+3)'(q_sgn);
    if (sum > FIELD_MAX) begin
      out_edge_new_nxt = FIELD_MAX[FIELD_W-1:0];
    end else if (sum < FIELD_MIN) begin
      out_edge_new_nxt = FIELD_MIN[FIELD_W-1:0];
    end else begin
      out_edge_new_nxt = sum[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    out_edge_new_r <= out_edge_new_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_edge_new = out_edge_new_r;

  // A result only appears a fixed pipeline depth after a request.
  `MBCU_CHK(a_fixed_latency, out_valid |-> $past(start, LAT), "result without request")
  // Writes to unknown register indexes leave both Courant registers alone.
  `MBCU_CHK(a_cfg_ignore, cfg_unmapped |=> $stable({courant_x_r, courant_y_r}), "bad index wrote")
  // Reset flushes the whole pipeline.
  `MBCU_CHK_NORST(a_reset_flush, !rst_n |=> !out_valid, "result strobe right after reset")

endmodule

[sv/mbcu_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage.
module mbcu_sqrt_pipe #(
  parameter int RW  = 20,
  parameter int SBW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_v,
  input  logic [2*RW-1:0] in_rad,
  input  logic [SBW-1:0]  in_sb,
  output logic            out_v,
  output logic [RW-1:0]   out_root,
  output logic [SBW-1:0]  out_sb
);

  logic            v_r    [RW];
  logic [2*RW-1:0] x_r    [RW];
  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [SBW-1:0]  sb_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            v_p;
    logic [2*RW-1:0] x_p;
    logic [RW+1:0]   rem_p;
    logic [RW-1:0]   root_p;
    logic [SBW-1:0]  sb_p;
    logic [RW+3:0]   rem_sh;
    logic [RW+3:0]   trial;
    logic [RW+1:0]   rem_nxt;
    logic [RW-1:0]   root_nxt;

    if (k == 0) begin : g_first
      assign v_p    = in_v;
      assign x_p    = in_rad;
      assign rem_p  = '0;
      assign root_p = '0;
      assign sb_p   = in_sb;
    end else begin : g_next
      assign v_p    = v_r[k-1];
      assign x_p    = x_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign sb_p   = sb_r[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {rem_p, x_p[2*RW-1 -: 2]};
    assign trial  = {2'b00, root_p, 2'b01};

    always_comb begin
      if (rem_sh >= trial) begin
        rem_nxt  = (RW+2)'(rem_sh - trial);
        root_nxt = {root_p[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[RW+1:0];
        root_nxt = {root_p[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      x_r[k]    <= x_p << 2;
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      sb_r[k]   <= sb_p;
    end
  end

  assign out_v    = v_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_sb   = sb_r[RW-1];

endmodule

[sv/mbcu_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, MSB first.
module mbcu_div_pipe #(
  parameter int DW  = 21,
  parameter int NW  = 54,
  parameter int QW  = 33,
  parameter int SBW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_v,
  input  logic [NW-1:0]  in_num,
  input  logic [DW-1:0]  in_den,
  input  logic [SBW-1:0] in_sb,
  output logic           out_v,
  output logic [QW-1:0]  out_quot,
  output logic [SBW-1:0] out_sb
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic           v_r   [QW];
  logic [CW-1:0]  rem_r [QW];
  logic [DW-1:0]  den_r [QW];
  logic [QW-1:0]  q_r   [QW];
  logic [SBW-1:0] sb_r  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic           v_p;
    logic [CW-1:0]  rem_p;
    logic [DW-1:0]  den_p;
    logic [QW-1:0]  q_p;
    logic [SBW-1:0] sb_p;
    logic [CW-1:0]  dsh;
    logic [CW-1:0]  rem_nxt;
    logic           bit_nxt;

    if (k == 0) begin : g_first
      assign v_p   = in_v;
      assign rem_p = CW'(in_num);
      assign den_p = in_den;
      assign q_p   = '0;
      assign sb_p  = in_sb;
    end else begin : g_next
      assign v_p   = v_r[k-1];
      assign rem_p = rem_r[k-1];
      assign den_p = den_r[k-1];
      assign q_p   = q_r[k-1];
      assign sb_p  = sb_r[k-1];
    end

    assign dsh = CW'(den_p) << (QW - 1 - k);

    always_comb begin
      if (rem_p >= dsh) begin
        rem_nxt = rem_p - dsh;
        bit_nxt = 1'b1;
      end else begin
        rem_nxt = rem_p;
        bit_nxt = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      den_r[k] <= den_p;
      q_r[k]   <= {q_p[QW-2:0], bit_nxt};
      sb_r[k]  <= sb_p;
    end
  end

  assign out_v    = v_r[QW-1];
  assign out_quot = q_r[QW-1];
  assign out_sb   = sb_r[QW-1];

endmodule
